>>> rtl/assert_macros.svh
// Assertion macros used by the checker of the level bar mapper.
// Depends on nothing; the including scope must provide clk_i and rst_ni.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Check a property at every rising clock edge outside reset.
`define DLBM_ASSERT_CLK(name, prop, msg) \
  name: assert property (@(posedge clk_i) disable iff (!rst_ni) (prop)) \
    else $error(msg);

// Check that a condition holds in the cycle after a trigger.
`define DLBM_ASSERT_NEXT(name, trig, cons, msg) \
  name: assert property (@(posedge clk_i) disable iff (!rst_ni) (trig) |=> (cons)) \
    else $error(msg);

`endif

>>> rtl/dlbm_pkg.sv
// Shared widths, codes and controller/datapath interface types for the
// decimating level bar mapper. Depends on nothing.
package dlbm_pkg;

  localparam int unsigned BOUND_W   = 24;  // Q7.16 bounds and shown value
  localparam int unsigned CNT_W     = 16;  // decimation count
  localparam int unsigned IDX_W     = 32;  // running sample index
  localparam int unsigned SUM_W     = 64;  // accumulator
  localparam int unsigned DIV_W     = 25;  // divisor of the shared divider
  localparam int unsigned STEP_W    = 6;   // divider cycle counter
  localparam int unsigned BAR_OUT_W = 7;   // bar position port
  localparam int unsigned CLIP_W    = 2;
  localparam int unsigned MODE_W    = 2;
  localparam int unsigned CFG_IDX_W = 2;
  localparam int unsigned FRAC_BITS = 16;

  // Radix-4 divider: two quotient bits per cycle over the full accumulator.
  localparam int unsigned MAIN_CYCLES = SUM_W / 2;

  // Decimation modes; code 3 behaves as skip.
  localparam logic [MODE_W-1:0] MODE_AVG    = 2'd0;
  localparam logic [MODE_W-1:0] MODE_ENERGY = 2'd1;
  localparam logic [MODE_W-1:0] MODE_SKIP   = 2'd2;

  // Clip codes.
  localparam logic [CLIP_W-1:0] CLIP_NONE = 2'd0;
  localparam logic [CLIP_W-1:0] CLIP_LOW  = 2'd1;
  localparam logic [CLIP_W-1:0] CLIP_HIGH = 2'd2;
  localparam logic [CLIP_W-1:0] CLIP_BAD  = 2'd3;

  // Configuration register indexes.
  localparam logic [CFG_IDX_W-1:0] REG_LOWER = 2'd0;
  localparam logic [CFG_IDX_W-1:0] REG_UPPER = 2'd1;
  localparam logic [CFG_IDX_W-1:0] REG_COUNT = 2'd2;
  localparam logic [CFG_IDX_W-1:0] REG_MODE  = 2'd3;

  localparam logic [BOUND_W-1:0] LOWER_RESET = 24'hFF0000;  // -1.0
  localparam logic [BOUND_W-1:0] UPPER_RESET = 24'h010000;  // +1.0

  // Commands from the controller to the datapath.
  typedef struct packed {
    logic take;       // latch the input sample
    logic square;     // register the sample's square
    logic acc;        // accumulate and count
    logic load_main;  // start the group division, clear the group
    logic sat;        // saturate the quotient into the decimated value
    logic map;        // clamp and flag the decimated value
    logic load_pos;   // start the bar position division
    logic out_load;   // move the result into the output register
  } cmd_t;

  // Status from the datapath to the controller.
  typedef struct packed {
    logic emit;       // this sample ends a group (or no decimation)
    logic need_div;   // the group result needs the divider
    logic div_busy;   // divider still iterating
  } stat_t;

endpackage

>>> rtl/dlbm_div.sv
// Shared iterative unsigned divider, two quotient bits per cycle.
// Depends on dlbm_pkg for widths.
module dlbm_div (
  input  logic                          clk_i,
  input  logic                          rst_ni,
  input  logic                          start_i,
  input  logic [dlbm_pkg::SUM_W-1:0]    dividend_i,
  input  logic [dlbm_pkg::DIV_W-1:0]    divisor_i,
  input  logic [dlbm_pkg::STEP_W-1:0]   cycles_i,
  output logic                          busy_o,
  output logic [dlbm_pkg::SUM_W-1:0]    quot_o
);

  localparam int unsigned SW = dlbm_pkg::SUM_W;
  localparam int unsigned DW = dlbm_pkg::DIV_W;

  logic [SW-1:0]                   num_q, num_d;
  logic [DW-1:0]                   rem_q, rem_d;
  logic [DW-1:0]                   den_q;
  logic [dlbm_pkg::STEP_W-1:0]     cnt_q;

  // Dividend shifts out at the top while quotient bits shift in below.
  always_comb begin
    logic [DW:0] trial;
    num_d = num_q;
    rem_d = rem_q;
    for (int s = 0; s < 2; s++) begin
      trial = {rem_d, num_d[SW-1]};
      num_d = {num_d[SW-2:0], 1'b0};
      if (trial >= {1'b0, den_q}) begin
        trial    = trial - {1'b0, den_q};
        num_d[0] = 1'b1;
      end
      rem_d = trial[DW-1:0];
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cnt_q <= '0;
    end else if (start_i) begin
      cnt_q <= cycles_i;
    end else if (cnt_q != '0) begin
      cnt_q <= cnt_q - 1'b1;
    end
  end

  always_ff @(posedge clk_i) begin
    if (start_i) begin
      num_q <= dividend_i;
      rem_q <= '0;
      den_q <= divisor_i;
    end else if (cnt_q != '0) begin
      num_q <= num_d;
      rem_q <= rem_d;
    end
  end

  assign busy_o = (cnt_q != '0);
  assign quot_o = num_q;

endmodule

>>> rtl/dlbm_dp.sv
// Datapath of the level bar mapper: accumulator, saturation, clamp, bar
// position and output register. Depends on dlbm_pkg and dlbm_div.
module dlbm_dp #(
  parameter int unsigned SAMPLE_BITS = 24,
  parameter int unsigned BAR_WIDTH   = 70
) (
  input  logic                              clk_i,
  input  logic                              rst_ni,
  input  dlbm_pkg::cmd_t                    cmd_i,
  output dlbm_pkg::stat_t                   stat_o,
  input  logic [SAMPLE_BITS-1:0]            sample_value_i,
  input  logic [dlbm_pkg::BOUND_W-1:0]      lower_bound_i,
  input  logic [dlbm_pkg::BOUND_W-1:0]      upper_bound_i,
  input  logic [dlbm_pkg::CNT_W-1:0]        decimate_count_i,
  input  logic [dlbm_pkg::MODE_W-1:0]       decimate_mode_i,
  output logic [dlbm_pkg::IDX_W-1:0]        sample_index_o,
  output logic [dlbm_pkg::BAR_OUT_W-1:0]    bar_position_o,
  output logic [dlbm_pkg::CLIP_W-1:0]       clip_code_o,
  output logic [dlbm_pkg::BOUND_W-1:0]      shown_value_o
);

  localparam int unsigned SB     = SAMPLE_BITS;
  localparam int unsigned SW     = dlbm_pkg::SUM_W;
  localparam int unsigned BW     = dlbm_pkg::BOUND_W;
  localparam int unsigned SQ_W   = 2 * SAMPLE_BITS;
  localparam int unsigned CMP_W  = ((SAMPLE_BITS > dlbm_pkg::BOUND_W) ?
                                    SAMPLE_BITS : dlbm_pkg::BOUND_W) + 1;
  localparam int unsigned POS_NUM_W  = dlbm_pkg::BOUND_W + $clog2(2 * BAR_WIDTH + 1);
  localparam int unsigned POS_CYCLES = (POS_NUM_W + 1) / 2;
  localparam int unsigned POS_BITS   = 2 * POS_CYCLES;

  localparam logic [SW-1:0] SMAX     = {{(SW-SB+1){1'b0}}, {(SB-1){1'b1}}};
  localparam logic [SW-1:0] SMIN_MAG = SMAX + 1'b1;
  localparam logic [SB-1:0] SMAX_S   = {1'b0, {(SB-1){1'b1}}};
  localparam logic [SB-1:0] SMIN_S   = {1'b1, {(SB-1){1'b0}}};
  localparam logic signed [CMP_W-1:0] BMAX_E = {{(CMP_W-BW+1){1'b0}}, {(BW-1){1'b1}}};
  localparam logic signed [CMP_W-1:0] BMIN_E = {{(CMP_W-BW+1){1'b1}}, {(BW-1){1'b0}}};
  localparam logic [POS_NUM_W-1:0] TWO_BW = POS_NUM_W'(2 * BAR_WIDTH);

  // Control state
  logic [SW-1:0]                  sum_q, sum_d;
  logic [dlbm_pkg::CNT_W-1:0]     gcnt_q, gcnt_d;
  logic [dlbm_pkg::IDX_W-1:0]     idx_q, idx_d;

  // Payload
  logic [SB-1:0]                  x_q;
  logic [SQ_W-1:0]                sq_q;
  logic [SB-1:0]                  val_q;
  logic                           neg_q;
  logic [BW-1:0]                  shown_q;
  logic [dlbm_pkg::CLIP_W-1:0]    clip_q;
  logic [BW-1:0]                  off_q;
  logic [dlbm_pkg::IDX_W-1:0]     out_idx_q;
  logic [dlbm_pkg::BAR_OUT_W-1:0] out_bar_q;
  logic [dlbm_pkg::CLIP_W-1:0]    out_clip_q;
  logic [BW-1:0]                  out_shown_q;

  logic [SB-1:0]                  mag;
  logic [SW-1:0]                  x_ext, addend, sum_add;
  logic [dlbm_pkg::CNT_W-1:0]     gcnt_inc;
  logic                           n_zero, emit, need_div, sum_neg;
  logic [SW-1:0]                  main_dividend, energy_q;
  logic [SB-1:0]                  val_sat;
  logic signed [CMP_W-1:0]        val_e, lo_e, hi_e, valc_e, off_w, span_w;
  logic [dlbm_pkg::CLIP_W-1:0]    clip_m;
  logic [BW-1:0]                  span;
  logic [POS_NUM_W-1:0]           pos_num;
  logic [SW-1:0]                  pos_dividend;
  logic                           div_start, div_busy;
  logic [SW-1:0]                  div_dividend, quot;
  logic [dlbm_pkg::DIV_W-1:0]     div_divisor;
  logic [dlbm_pkg::STEP_W-1:0]    div_cycles;
  logic [dlbm_pkg::IDX_W-1:0]     advance;

  // Accumulate and group end
  assign mag      = x_q[SB-1] ? (~x_q + 1'b1) : x_q;
  assign x_ext    = {{(SW-SB){x_q[SB-1]}}, x_q};
  assign gcnt_inc = gcnt_q + 1'b1;
  assign n_zero   = (decimate_count_i == '0);
  assign emit     = n_zero || (gcnt_inc >= decimate_count_i);
  assign need_div = !n_zero && emit &&
                    ((decimate_mode_i == dlbm_pkg::MODE_AVG) ||
                     (decimate_mode_i == dlbm_pkg::MODE_ENERGY));

  always_comb begin
    priority if (decimate_mode_i == dlbm_pkg::MODE_AVG) begin
      addend = x_ext;
    end else if (decimate_mode_i == dlbm_pkg::MODE_ENERGY) begin
      addend = SW'(sq_q);
    end else begin
      addend = '0;
    end
  end

  assign sum_add       = sum_q + addend;
  assign sum_neg       = (decimate_mode_i == dlbm_pkg::MODE_AVG) && sum_q[SW-1];
  assign main_dividend = sum_neg ? (~sum_q + 1'b1) : sum_q;
  assign advance       = n_zero ? dlbm_pkg::IDX_W'(1) : dlbm_pkg::IDX_W'(decimate_count_i);

  always_comb begin
    sum_d  = sum_q;
    gcnt_d = gcnt_q;
    idx_d  = idx_q;
    if (cmd_i.acc) begin
      if (n_zero || (emit && !need_div)) begin
        sum_d  = '0;
        gcnt_d = '0;
      end else begin
        sum_d  = sum_add;
        gcnt_d = gcnt_inc;
      end
    end
    if (cmd_i.load_main) begin
      sum_d  = '0;
      gcnt_d = '0;
    end
    if (cmd_i.out_load) begin
      idx_d = idx_q + advance;
    end
  end

  // Saturate the group quotient
  assign energy_q = quot >> dlbm_pkg::FRAC_BITS;

  always_comb begin
    priority if (decimate_mode_i == dlbm_pkg::MODE_ENERGY) begin
      val_sat = (energy_q > SMAX) ? SMAX_S : energy_q[SB-1:0];
    end else if (neg_q) begin
      val_sat = (quot > SMIN_MAG) ? SMIN_S : (~quot[SB-1:0] + 1'b1);
    end else begin
      val_sat = (quot > SMAX) ? SMAX_S : quot[SB-1:0];
    end
  end

  // Clamp against the bounds
  assign val_e  = {{(CMP_W-SB){val_q[SB-1]}}, val_q};
  assign lo_e   = {{(CMP_W-BW){lower_bound_i[BW-1]}}, lower_bound_i};
  assign hi_e   = {{(CMP_W-BW){upper_bound_i[BW-1]}}, upper_bound_i};
  assign span_w = hi_e - lo_e;
  assign span   = span_w[BW-1:0];

  always_comb begin
    if (lo_e >= hi_e) begin
      clip_m = dlbm_pkg::CLIP_BAD;
      priority if (val_e > BMAX_E) begin
        valc_e = BMAX_E;
      end else if (val_e < BMIN_E) begin
        valc_e = BMIN_E;
      end else begin
        valc_e = val_e;
      end
    end else begin
      priority if (val_e < lo_e) begin
        clip_m = dlbm_pkg::CLIP_LOW;
        valc_e = lo_e;
      end else if (val_e > hi_e) begin
        clip_m = dlbm_pkg::CLIP_HIGH;
        valc_e = hi_e;
      end else begin
        clip_m = dlbm_pkg::CLIP_NONE;
        valc_e = val_e;
      end
    end
  end

  assign off_w = valc_e - lo_e;

  // Bar position: (off * 2 * BAR_WIDTH + span) / (2 * span)
  assign pos_num      = POS_NUM_W'(off_q) * TWO_BW + POS_NUM_W'(span);
  assign pos_dividend = SW'(pos_num) << (SW - POS_BITS);

  assign div_start    = cmd_i.load_main | cmd_i.load_pos;
  assign div_dividend = cmd_i.load_pos ? pos_dividend : main_dividend;
  assign div_divisor  = cmd_i.load_pos ? {span, 1'b0} : dlbm_pkg::DIV_W'(decimate_count_i);
  assign div_cycles   = cmd_i.load_pos ? dlbm_pkg::STEP_W'(POS_CYCLES) :
                                         dlbm_pkg::STEP_W'(dlbm_pkg::MAIN_CYCLES);

  dlbm_div u_div (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .start_i    (div_start),
    .dividend_i (div_dividend),
    .divisor_i  (div_divisor),
    .cycles_i   (div_cycles),
    .busy_o     (div_busy),
    .quot_o     (quot)
  );

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      sum_q  <= '0;
      gcnt_q <= '0;
      idx_q  <= '0;
    end else begin
      sum_q  <= sum_d;
      gcnt_q <= gcnt_d;
      idx_q  <= idx_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (cmd_i.take) begin
      x_q <= sample_value_i;
    end
    if (cmd_i.square) begin
      sq_q <= SQ_W'(mag) * SQ_W'(mag);
    end
    if (cmd_i.acc) begin
      val_q <= x_q;
    end
    if (cmd_i.load_main) begin
      neg_q <= sum_neg;
    end
    if (cmd_i.sat) begin
      val_q <= val_sat;
    end
    if (cmd_i.map) begin
      shown_q <= valc_e[BW-1:0];
      clip_q  <= clip_m;
      off_q   <= off_w[BW-1:0];
    end
    if (cmd_i.out_load) begin
      out_idx_q   <= idx_q;
      out_bar_q   <= (clip_q == dlbm_pkg::CLIP_BAD) ? '0 : quot[dlbm_pkg::BAR_OUT_W-1:0];
      out_clip_q  <= clip_q;
      out_shown_q <= shown_q;
    end
  end

  assign stat_o.emit     = emit;
  assign stat_o.need_div = need_div;
  assign stat_o.div_busy = div_busy;

  assign sample_index_o = out_idx_q;
  assign bar_position_o = out_bar_q;
  assign clip_code_o    = out_clip_q;
  assign shown_value_o  = out_shown_q;

endmodule

>>> rtl/dlbm_ctrl.sv
// Sequencing controller of the level bar mapper and the output valid flag.
// Depends on dlbm_pkg for the command and status structs.
module dlbm_ctrl (
  input  logic            clk_i,
  input  logic            rst_ni,
  input  logic            in_valid_i,
  output logic            in_ready_o,
  output logic            out_valid_o,
  input  logic            out_ready_i,
  input  dlbm_pkg::stat_t stat_i,
  output dlbm_pkg::cmd_t  cmd_o
);

  typedef enum logic [9:0] {
    ST_IDLE   = 10'b00_0000_0001,
    ST_SQUARE = 10'b00_0000_0010,
    ST_ACC    = 10'b00_0000_0100,
    ST_LOAD   = 10'b00_0000_1000,
    ST_DIV    = 10'b00_0001_0000,
    ST_SAT    = 10'b00_0010_0000,
    ST_MAP    = 10'b00_0100_0000,
    ST_PLOAD  = 10'b00_1000_0000,
    ST_PDIV   = 10'b01_0000_0000,
    ST_OUT    = 10'b10_0000_0000
  } state_e;

  state_e state_q, state_d;
  logic   out_valid_q, out_valid_d;

  always_comb begin
    state_d = state_q;
    cmd_o   = '0;
    unique case (state_q)
      ST_IDLE: begin
        if (in_valid_i) begin
          cmd_o.take = 1'b1;
          state_d    = ST_SQUARE;
        end
      end
      ST_SQUARE: begin
        cmd_o.square = 1'b1;
        state_d      = ST_ACC;
      end
      ST_ACC: begin
        cmd_o.acc = 1'b1;
        priority if (!stat_i.emit) begin
          state_d = ST_IDLE;
        end else if (stat_i.need_div) begin
          state_d = ST_LOAD;
        end else begin
          state_d = ST_MAP;
        end
      end
      ST_LOAD: begin
        cmd_o.load_main = 1'b1;
        state_d         = ST_DIV;
      end
      ST_DIV: begin
        if (!stat_i.div_busy) begin
          state_d = ST_SAT;
        end
      end
      ST_SAT: begin
        cmd_o.sat = 1'b1;
        state_d   = ST_MAP;
      end
      ST_MAP: begin
        cmd_o.map = 1'b1;
        state_d   = ST_PLOAD;
      end
      ST_PLOAD: begin
        cmd_o.load_pos = 1'b1;
        state_d        = ST_PDIV;
      end
      ST_PDIV: begin
        if (!stat_i.div_busy) begin
          state_d = ST_OUT;
        end
      end
      ST_OUT: begin
        // hold until the output register is free
        if (!out_valid_q || out_ready_i) begin
          cmd_o.out_load = 1'b1;
          state_d        = ST_IDLE;
        end
      end
      default: begin
        state_d = ST_IDLE;
      end
    endcase
  end

  always_comb begin
    priority if (cmd_o.out_load) begin
      out_valid_d = 1'b1;
    end else if (out_ready_i) begin
      out_valid_d = 1'b0;
    end else begin
      out_valid_d = out_valid_q;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= ST_IDLE;
      out_valid_q <= 1'b0;
    end else begin
      state_q     <= state_d;
      out_valid_q <= out_valid_d;
    end
  end

  assign in_ready_o  = (state_q == ST_IDLE);
  assign out_valid_o = out_valid_q;

endmodule

>>> rtl/decimating_level_bar_mapper.sv
// Top level of the decimating level bar mapper: configuration registers,
// controller and datapath. Depends on dlbm_pkg, dlbm_ctrl and dlbm_dp.
//
// Takes signed Q7.16 samples, one transaction at a time, and optionally
// reduces each group of decimate_count samples to one value: the mean
// (average mode), the mean square brought back to Q7.16 (energy mode) or
// the last sample of the group (skip mode, and mode code 3). A count of
// zero passes every sample. Each emitted value carries the index of the
// first sample of its group, is clamped to [lower_bound, upper_bound] with
// a clip code, and is mapped to a bar position 0..BAR_WIDTH, rounded half
// up; a lower bound at or above the upper bound gives position 0 and clip
// code 3. A sample that does not end a group is accepted, squared and
// accumulated. A result without a group division then passes through the
// clamp, the bar position division and the output register; an average or
// energy result first runs the group division and saturation. Both
// divisions run on one shared divider that retires two quotient bits per
// cycle. A finished result waits in the output register while the next
// sample is taken; the block stalls only if a second result is ready
// before the first leaves. Configuration writes take effect at once and
// belong between samples.
module decimating_level_bar_mapper #(
  parameter int unsigned BAR_WIDTH   = 70,
  parameter int unsigned SAMPLE_BITS = 24
) (
  input  logic                               clk_i,
  input  logic                               rst_ni,
  // configuration write port
  input  logic                               cfg_we_i,
  input  logic [dlbm_pkg::CFG_IDX_W-1:0]     cfg_idx_i,
  input  logic [dlbm_pkg::BOUND_W-1:0]       cfg_wdata_i,
  // sample input
  input  logic                               in_valid_i,
  output logic                               in_ready_o,
  input  logic [SAMPLE_BITS-1:0]             sample_value_i,
  // result output
  output logic                               out_valid_o,
  input  logic                               out_ready_i,
  output logic [dlbm_pkg::IDX_W-1:0]         sample_index_o,
  output logic [dlbm_pkg::BAR_OUT_W-1:0]     bar_position_o,
  output logic [dlbm_pkg::CLIP_W-1:0]        clip_code_o,
  output logic [dlbm_pkg::BOUND_W-1:0]       shown_value_o
);

  logic [dlbm_pkg::BOUND_W-1:0] lower_q;
  logic [dlbm_pkg::BOUND_W-1:0] upper_q;
  logic [dlbm_pkg::CNT_W-1:0]   count_q;
  logic [dlbm_pkg::MODE_W-1:0]  mode_q;

  dlbm_pkg::cmd_t  cmd;
  dlbm_pkg::stat_t stat;

  // Register writes land immediately; nothing in the group state is cleared.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      lower_q <= dlbm_pkg::LOWER_RESET;
      upper_q <= dlbm_pkg::UPPER_RESET;
      count_q <= '0;
      mode_q  <= dlbm_pkg::MODE_AVG;
    end else if (cfg_we_i) begin
      unique case (cfg_idx_i)
        dlbm_pkg::REG_LOWER: lower_q <= cfg_wdata_i;
        dlbm_pkg::REG_UPPER: upper_q <= cfg_wdata_i;
        dlbm_pkg::REG_COUNT: count_q <= cfg_wdata_i[dlbm_pkg::CNT_W-1:0];
        dlbm_pkg::REG_MODE:  mode_q  <= cfg_wdata_i[dlbm_pkg::MODE_W-1:0];
      endcase
    end
  end

  // Sequence each transaction through the datapath.
  dlbm_ctrl u_ctrl (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .in_valid_i  (in_valid_i),
    .in_ready_o  (in_ready_o),
    .out_valid_o (out_valid_o),
    .out_ready_i (out_ready_i),
    .stat_i      (stat),
    .cmd_o       (cmd)
  );

  // Accumulator, divider, clamp and output register.
  dlbm_dp #(
    .SAMPLE_BITS (SAMPLE_BITS),
    .BAR_WIDTH   (BAR_WIDTH)
  ) u_dp (
    .clk_i            (clk_i),
    .rst_ni           (rst_ni),
    .cmd_i            (cmd),
    .stat_o           (stat),
    .sample_value_i   (sample_value_i),
    .lower_bound_i    (lower_q),
    .upper_bound_i    (upper_q),
    .decimate_count_i (count_q),
    .decimate_mode_i  (mode_q),
    .sample_index_o   (sample_index_o),
    .bar_position_o   (bar_position_o),
    .clip_code_o      (clip_code_o),
    .shown_value_o    (shown_value_o)
  );

endmodule

>>> rtl/dlbm_chk.sv
// Port-level checker for the level bar mapper, bound to the top level.
// Depends on dlbm_pkg and assert_macros.svh.
`include "assert_macros.svh"

module dlbm_chk #(
  parameter int unsigned BAR_WIDTH = 70
) (
  input logic                            clk_i,
  input logic                            rst_ni,
  input logic                            in_valid_i,
  input logic                            in_ready_o,
  input logic                            out_valid_o,
  input logic                            out_ready_i,
  input logic [dlbm_pkg::IDX_W-1:0]      sample_index_o,
  input logic [dlbm_pkg::BAR_OUT_W-1:0]  bar_position_o,
  input logic [dlbm_pkg::CLIP_W-1:0]     clip_code_o,
  input logic [dlbm_pkg::BOUND_W-1:0]    shown_value_o
);

  `DLBM_ASSERT_NEXT(a_out_hold, out_valid_o && !out_ready_i, out_valid_o, "result dropped before transaction")

  `DLBM_ASSERT_NEXT(a_out_stable, out_valid_o && !out_ready_i, $stable(sample_index_o) && $stable(bar_position_o) && $stable(clip_code_o) && $stable(shown_value_o), "result changed while stalled")

  `DLBM_ASSERT_NEXT(a_busy_after_take, in_valid_i && in_ready_o, !in_ready_o, "second sample taken while busy")

  `DLBM_ASSERT_CLK(a_bad_range_pos, !out_valid_o || (clip_code_o != dlbm_pkg::CLIP_BAD) || (bar_position_o == '0), "bad range with nonzero bar")

  `DLBM_ASSERT_CLK(a_bar_range, !out_valid_o || (BAR_WIDTH > 127) || (bar_position_o <= BAR_WIDTH), "bar position beyond bar width")

endmodule

bind decimating_level_bar_mapper dlbm_chk #(
  .BAR_WIDTH (BAR_WIDTH)
) u_dlbm_chk (
  .clk_i          (clk_i),
  .rst_ni         (rst_ni),
  .in_valid_i     (in_valid_i),
  .in_ready_o     (in_ready_o),
  .out_valid_o    (out_valid_o),
  .out_ready_i    (out_ready_i),
  .sample_index_o (sample_index_o),
  .bar_position_o (bar_position_o),
  .clip_code_o    (clip_code_o),
  .shown_value_o  (shown_value_o)
);

>>> test/decimating_level_bar_mapper_test.sv
// Self-checking test of decimating_level_bar_mapper: directed and random samples under
// random stalls, with an in-bench tracker that predicts every result.
// Depends on dlbm_pkg and the decimating_level_bar_mapper RTL.
module decimating_level_bar_mapper_test;
  import dlbm_pkg::*;

  localparam int unsigned BAR_COUNT = 70;
  localparam int unsigned SAMPLE_W  = 24;

  localparam int unsigned ITEM_TARGET   = 1850;
  localparam int unsigned QUIET_LIMIT   = 5000;  // cycles with no transaction at all
  localparam int unsigned SETTLE_CYCLES = 80;
  localparam int unsigned LONG_HOLD     = 400;
  localparam int unsigned CALM_TAIL     = 250;   // items sent with no idling at the end

  localparam logic [SAMPLE_W-1:0] Q_MIN       = 24'h800000;
  localparam logic [SAMPLE_W-1:0] Q_MAX       = 24'h7FFFFF;
  localparam logic [SAMPLE_W-1:0] Q_ONE       = 24'h010000;
  localparam logic [SAMPLE_W-1:0] Q_MINUS_ONE = 24'hFF0000;

  // Mode code 3 has no name of its own; the block treats it as skip.
  localparam logic [MODE_W-1:0] MODE_SKIP_ALT = 2'd3;

  localparam logic [63:0] SAMPLE_MAX = (64'd1 << (SAMPLE_W - 1)) - 64'd1;
  localparam logic [63:0] BAR_SCALE  = 64'(2 * BAR_COUNT);

  typedef struct packed {
    logic [IDX_W-1:0]     index;
    logic [BAR_OUT_W-1:0] bar;
    logic [CLIP_W-1:0]    clip;
    logic [BOUND_W-1:0]   shown;
  } bar_result_t;

  // Tracks registers and group state, and queues the bar result each sample causes.
  class level_bar_tracker;
    logic [BOUND_W-1:0] lower;
    logic [BOUND_W-1:0] upper;
    logic [CNT_W-1:0]   count;
    logic [MODE_W-1:0]  mode;
    logic [CNT_W-1:0]   gathered;
    logic [SUM_W-1:0]   acc;
    logic [IDX_W-1:0]   next_index;
    bar_result_t        pending_bars[$];
    int unsigned        errors;

    function new();
      lower      = LOWER_RESET;
      upper      = UPPER_RESET;
      count      = '0;
      mode       = MODE_AVG;
      gathered   = '0;
      acc        = '0;
      next_index = '0;
      errors     = 0;
    endfunction

    function void write_reg(logic [CFG_IDX_W-1:0] idx, logic [BOUND_W-1:0] data);
      case (idx)
        REG_LOWER: lower = data;
        REG_UPPER: upper = data;
        REG_COUNT: count = data[CNT_W-1:0];
        default:   mode = data[MODE_W-1:0];
      endcase
    endfunction

    function void take_sample(logic [SAMPLE_W-1:0] raw);
      logic signed [63:0] x, val, lo, hi, span, off;
      logic [63:0]        mag, m, q, div, pos;
      logic [IDX_W-1:0]   advance;
      logic               neg;
      bar_result_t        r;
      x = {{(64 - SAMPLE_W){raw[SAMPLE_W-1]}}, raw};
      if (count == '0) begin
        val      = x;
        gathered = '0;
        acc      = '0;
        advance  = 32'd1;
      end else begin
        mag = x[63] ? -x : x;
        if (mode == MODE_AVG) begin
          acc = acc + x;
        end else if (mode == MODE_ENERGY) begin
          acc = acc + mag * mag;
        end
        gathered = gathered + 1'b1;
        // A group ends once the count reaches or passes N, even if N was lowered.
        if (gathered < count) return;
        div = {48'd0, count};
        if (mode == MODE_AVG) begin
          neg = acc[63];
          m   = neg ? -acc : acc;
          q   = m / div;
          if (neg) begin
            if (q > SAMPLE_MAX + 64'd1) q = SAMPLE_MAX + 64'd1;
            val = -$signed(q);
          end else begin
            if (q > SAMPLE_MAX) q = SAMPLE_MAX;
            val = $signed(q);
          end
        end else if (mode == MODE_ENERGY) begin
          q = (acc / div) >> FRAC_BITS;
          if (q > SAMPLE_MAX) q = SAMPLE_MAX;
          val = $signed(q);
        end else begin
          val = x;
        end
        gathered = '0;
        acc      = '0;
        advance  = {16'd0, count};
      end
      r.index    = next_index;
      next_index = next_index + advance;
      lo = {{(64 - BOUND_W){lower[BOUND_W-1]}}, lower};
      hi = {{(64 - BOUND_W){upper[BOUND_W-1]}}, upper};
      if (lo >= hi) begin
        // Bad range: no bar, and the value already fits the bound width.
        r.clip = CLIP_BAD;
        r.bar  = '0;
      end else begin
        r.clip = CLIP_NONE;
        if (val < lo) begin
          r.clip = CLIP_LOW;
          val    = lo;
        end
        if (val > hi) begin
          r.clip = CLIP_HIGH;
          val    = hi;
        end
        span  = hi - lo;
        off   = val - lo;
        pos   = (off * BAR_SCALE + span) / (span << 1);
        r.bar = pos[BAR_OUT_W-1:0];
      end
      r.shown = val[BOUND_W-1:0];
      pending_bars.push_back(r);
    endfunction

    function void match_result(bar_result_t got);
      bar_result_t want;
      if (pending_bars.size() == 0) begin
        $error("result with sample_index %0d arrived with nothing expected", got.index);
        errors++;
        return;
      end
      want = pending_bars.pop_front();
      if (got.index !== want.index) begin
        $error("sample_index: expected %0d, got %0d", want.index, got.index);
        errors++;
      end
      if (got.bar !== want.bar) begin
        $error("bar_position: expected %0d, got %0d", want.bar, got.bar);
        errors++;
      end
      if (got.clip !== want.clip) begin
        $error("clip_code: expected %0d, got %0d", want.clip, got.clip);
        errors++;
      end
      if (got.shown !== want.shown) begin
        $error("shown_value: expected %0d, got %0d", $signed(want.shown), $signed(got.shown));
        errors++;
      end
    endfunction
  endclass

  logic                  clk_i = 1'b0;
  logic                  rst_ni;
  logic                  cfg_we_i;
  logic [CFG_IDX_W-1:0]  cfg_idx_i;
  logic [BOUND_W-1:0]    cfg_wdata_i;
  logic                  in_valid_i;
  logic                  in_ready_o;
  logic [SAMPLE_W-1:0]   sample_value_i;
  logic                  out_valid_o;
  logic                  out_ready_i;
  logic [IDX_W-1:0]      sample_index_o;
  logic [BAR_OUT_W-1:0]  bar_position_o;
  logic [CLIP_W-1:0]     clip_code_o;
  logic [BOUND_W-1:0]    shown_value_o;

  level_bar_tracker tracker;
  int unsigned      items_sent = 0;
  int unsigned      quiet_cycles = 0;
  // Idling controls; the receiver serves long holds as they are asked for.
  bit               send_gaps = 1'b0;
  bit               take_stalls = 1'b0;
  int unsigned      hold_asks = 0;
  int unsigned      holds_served = 0;

  decimating_level_bar_mapper #(
    .BAR_WIDTH  (BAR_COUNT),
    .SAMPLE_BITS(SAMPLE_W)
  ) dut (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .cfg_we_i      (cfg_we_i),
    .cfg_idx_i     (cfg_idx_i),
    .cfg_wdata_i   (cfg_wdata_i),
    .in_valid_i    (in_valid_i),
    .in_ready_o    (in_ready_o),
    .sample_value_i(sample_value_i),
    .out_valid_o   (out_valid_o),
    .out_ready_i   (out_ready_i),
    .sample_index_o(sample_index_o),
    .bar_position_o(bar_position_o),
    .clip_code_o   (clip_code_o),
    .shown_value_o (shown_value_o)
  );

  always begin
    #4 clk_i = 1'b1;
    #4 clk_i = 1'b0;
  end

  // Drop valid and idle the input side for a number of cycles.
  task automatic idle_input(input int unsigned cycles);
    in_valid_i <= 1'b0;
    repeat (cycles) @(posedge clk_i);
  endtask

  // Offer one sample and hold it until the transaction completes. Valid is left
  // high so that a following sample goes out back to back.
  task automatic send_sample(input logic [SAMPLE_W-1:0] value);
    if (send_gaps && $urandom_range(0, 4) == 0) idle_input($urandom_range(1, 17));
    sample_value_i <= value;
    in_valid_i     <= 1'b1;
    do @(posedge clk_i); while (in_ready_o !== 1'b1);
    tracker.take_sample(value);
    items_sent++;
  endtask

  // Write one register; the block must be idle.
  task automatic write_reg(input logic [CFG_IDX_W-1:0] idx, input logic [BOUND_W-1:0] data);
    cfg_we_i    <= 1'b1;
    cfg_idx_i   <= idx;
    cfg_wdata_i <= data;
    @(posedge clk_i);
    cfg_we_i <= 1'b0;
    @(posedge clk_i);
    tracker.write_reg(idx, data);
  endtask

  // Stop offering, wait for every expected result, then let a sample that
  // caused no result finish its work before any register changes.
  task automatic settle();
    in_valid_i <= 1'b0;
    while (tracker.pending_bars.size() != 0) @(posedge clk_i);
    repeat (SETTLE_CYCLES) @(posedge clk_i);
  endtask

  function automatic logic [SAMPLE_W-1:0] random_word();
    logic [31:0] r;
    r = $urandom();
    return r[SAMPLE_W-1:0];
  endfunction

  // Mix full-range noise, values around the current bounds, extremes and small values.
  function automatic logic [SAMPLE_W-1:0] random_sample();
    logic signed [63:0] lo, hi, span, v;
    logic [63:0]        width, r64, off;
    logic [31:0]        r;
    int unsigned        pick;
    lo   = {{(64 - BOUND_W){tracker.lower[BOUND_W-1]}}, tracker.lower};
    hi   = {{(64 - BOUND_W){tracker.upper[BOUND_W-1]}}, tracker.upper};
    pick = $urandom_range(0, 9);
    if (pick < 4 || lo >= hi) return random_word();
    if (pick < 8) begin
      span  = hi - lo;
      width = span + (span >>> 2) + 64'sd1;
      r64   = {$urandom(), $urandom()};
      off   = r64 % width;
      v     = lo - (span >>> 3) + $signed(off);
      if (v > $signed(SAMPLE_MAX)) v = $signed(SAMPLE_MAX);
      if (v < -$signed(SAMPLE_MAX) - 64'sd1) v = -$signed(SAMPLE_MAX) - 64'sd1;
      return v[SAMPLE_W-1:0];
    end
    if (pick == 8) begin
      case ($urandom_range(0, 5))
        0: return Q_MIN;
        1: return Q_MAX;
        2: return tracker.lower;
        3: return tracker.upper;
        4: return '0;
        default: return '1;
      endcase
    end
    r = $urandom_range(0, 262144) - 131072;
    return r[SAMPLE_W-1:0];
  endfunction

  // Pick new bounds: a bad range now and then, the full range, a random pair
  // or a narrow window.
  task automatic write_random_bounds();
    logic [BOUND_W-1:0] a, b, lo_w, hi_w;
    int                 c, h, t;
    int unsigned        pick;
    a    = random_word();
    b    = random_word();
    pick = $urandom_range(0, 9);
    if (pick == 0) begin
      lo_w = ($signed(a) >= $signed(b)) ? a : b;
      hi_w = ($signed(a) >= $signed(b)) ? b : a;
    end else if (pick == 1) begin
      lo_w = Q_MIN;
      hi_w = Q_MAX;
    end else if (pick < 6) begin
      lo_w = ($signed(a) < $signed(b)) ? a : b;
      hi_w = ($signed(a) < $signed(b)) ? b : a;
    end else begin
      c    = int'($urandom_range(0, 2097152)) - 1048576;
      h    = int'($urandom_range(1, 131072));
      t    = c - h;
      lo_w = t[BOUND_W-1:0];
      t    = c + h;
      hi_w = t[BOUND_W-1:0];
    end
    if ($urandom_range(0, 3) != 0) write_reg(REG_LOWER, lo_w);
    if ($urandom_range(0, 3) != 0) write_reg(REG_UPPER, hi_w);
  endtask

  function automatic logic [BOUND_W-1:0] random_count();
    int unsigned pick, n;
    pick = $urandom_range(0, 19);
    if (pick < 5)       n = 0;
    else if (pick < 15) n = $urandom_range(1, 8);
    else if (pick < 19) n = $urandom_range(9, 40);
    else                n = $urandom_range(41, 300);
    return n[BOUND_W-1:0];
  endfunction

  // One random phase: new settings, a burst of samples, then drain.
  task automatic run_phase(input int unsigned phase_no);
    logic [MODE_W-1:0] mode_pick;
    logic [31:0]       r;
    bit                calm, neg;
    int unsigned       kind, samples;
    calm        = items_sent + CALM_TAIL >= ITEM_TARGET;
    send_gaps   = !calm && $urandom_range(0, 9) < 7;
    take_stalls = !calm && $urandom_range(0, 9) < 7;
    kind        = $urandom_range(0, 11);
    if (phase_no == 2) begin
      // Pressure: hold the output side off while samples keep coming.
      write_reg(REG_COUNT, '0);
      send_gaps = 1'b0;
      hold_asks++;
      repeat (40) send_sample(random_sample());
    end else if (kind == 0 && !calm) begin
      // Fill a long group with one-signed extremes, then lower N so the next
      // sample ends the group and the quotient saturates.
      r         = $urandom_range(0, 1);
      mode_pick = r[MODE_W-1:0];
      neg       = $urandom_range(0, 1) != 0;
      write_reg(REG_MODE, {{(BOUND_W - MODE_W){1'b0}}, mode_pick});
      write_reg(REG_COUNT, 24'h00FFFF);
      samples = $urandom_range(16, 40);
      repeat (samples) begin
        r = $urandom_range(0, 255);
        send_sample(neg ? Q_MIN + r[SAMPLE_W-1:0] : Q_MAX - r[SAMPLE_W-1:0]);
      end
      settle();
      r = $urandom_range(1, 3);
      write_reg(REG_COUNT, r[BOUND_W-1:0]);
      send_sample(random_sample());
    end else begin
      write_random_bounds();
      if ($urandom_range(0, 3) != 0) write_reg(REG_COUNT, random_count());
      if ($urandom_range(0, 3) != 0) begin
        r = $urandom_range(0, 3);
        write_reg(REG_MODE, r[BOUND_W-1:0]);
      end
      samples = $urandom_range(8, 48);
      repeat (samples) send_sample(random_sample());
    end
    settle();
  endtask

  // Receiver: check each result transaction, then decide ready for the next cycle.
  initial begin
    int unsigned hold;
    bar_result_t got;
    hold = 0;
    out_ready_i <= 1'b0;
    forever begin
      @(posedge clk_i);
      if (!rst_ni) continue;
      if (out_valid_o && out_ready_i) begin
        got.index = sample_index_o;
        got.bar   = bar_position_o;
        got.clip  = clip_code_o;
        got.shown = shown_value_o;
        tracker.match_result(got);
      end
      if (hold > 0) begin
        hold--;
      end else if (holds_served < hold_asks) begin
        holds_served++;
        hold = LONG_HOLD;
        out_ready_i <= 1'b0;
      end else if (take_stalls && $urandom_range(0, 5) == 0) begin
        hold = $urandom_range(0, 16);
        out_ready_i <= 1'b0;
      end else begin
        out_ready_i <= 1'b1;
      end
    end
  end

  // Watchdog: end the run if no transaction happens on either side for too long.
  always @(posedge clk_i) begin
    if ((in_valid_i && in_ready_o) || (out_valid_o && out_ready_i)) begin
      quiet_cycles <= 0;
    end else if (quiet_cycles >= QUIET_LIMIT) begin
      $display("FAIL");
      $finish;
    end else begin
      quiet_cycles <= quiet_cycles + 1;
    end
  end

  initial begin
    int unsigned phase_no;
    tracker        = new();
    rst_ni         <= 1'b0;
    cfg_we_i       <= 1'b0;
    cfg_idx_i      <= REG_LOWER;
    cfg_wdata_i    <= '0;
    in_valid_i     <= 1'b0;
    sample_value_i <= '0;
    repeat (12) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    // Reset bounds -1.0 .. +1.0, no decimation: zero, both sample extremes,
    // both bounds exactly, and a value just below zero.
    send_sample('0);
    send_sample(Q_MIN);
    send_sample(Q_MAX);
    send_sample(Q_MINUS_ONE);
    send_sample(Q_ONE);
    send_sample('1);
    settle();

    // A span of 140 puts odd offsets exactly halfway between bar steps: round up.
    write_reg(REG_LOWER, 24'd0);
    write_reg(REG_UPPER, 24'd140);
    send_sample(24'd1);
    send_sample(24'd2);
    send_sample(24'd3);
    send_sample(24'd139);
    settle();

    // Bad range, first inverted at the extremes, then equal bounds.
    write_reg(REG_LOWER, Q_MAX);
    write_reg(REG_UPPER, Q_MIN);
    send_sample(Q_MIN);
    send_sample(Q_MAX);
    settle();
    write_reg(REG_UPPER, Q_MAX);
    send_sample('0);
    settle();

    // Full range, average of three with a negative sum truncated toward zero.
    write_reg(REG_LOWER, Q_MIN);
    write_reg(REG_COUNT, 24'd3);
    send_sample(Q_MIN);
    send_sample(Q_MIN);
    send_sample(Q_MAX);
    settle();

    // Energy at the largest count, then lower N mid-group: the next sample
    // ends the group and the mean square saturates.
    write_reg(REG_MODE, {{(BOUND_W - MODE_W){1'b0}}, MODE_ENERGY});
    write_reg(REG_COUNT, 24'h00FFFF);
    repeat (4) send_sample(Q_MIN);
    settle();
    write_reg(REG_COUNT, 24'd1);
    send_sample(Q_MIN);
    settle();

    // Mode code 3 behaves as skip: emit the last sample of the group.
    write_reg(REG_MODE, {{(BOUND_W - MODE_W){1'b0}}, MODE_SKIP_ALT});
    write_reg(REG_COUNT, 24'd2);
    send_sample(24'd5);
    send_sample(24'd7);
    settle();

    phase_no = 0;
    while (items_sent < ITEM_TARGET) begin
      run_phase(phase_no);
      phase_no++;
    end

    settle();
    if (tracker.errors == 0) begin
      $display("PASS");
    end else begin
      $display("FAIL");
    end
    $finish;
  end

endmodule
